/* src/pwfp_pkg.sv */
// ----------------------------------------------------------------------------
// pwfp_pkg
// Shared types and constants of the protobuf wire field parser: parser
// phases, wire types, result kinds and field widths.
// ----------------------------------------------------------------------------
package pwfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned TYPE_W   = 3;

    localparam logic [INDEX_W-1:0] VARINT_MAX_GROUPS = 4'd10;
    localparam logic [INDEX_W-1:0] FIXED64_BYTES     = 4'd8;
    localparam logic [INDEX_W-1:0] FIXED32_BYTES     = 4'd4;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [TYPE_W-1:0] WT_VARINT  = 3'd0;
    localparam logic [TYPE_W-1:0] WT_FIXED64 = 3'd1;
    localparam logic [TYPE_W-1:0] WT_LENGTH  = 3'd2;
    localparam logic [TYPE_W-1:0] WT_FIXED32 = 3'd5;

    localparam logic [KIND_W-1:0] KIND_VARINT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIXED64 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIXED32 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd4;

endpackage

/* src/protobuf_wire_field_parser_unit.sv */
// ----------------------------------------------------------------------------
// protobuf_wire_field_parser_unit
// Decodes a serialized protobuf message, one byte per item, into varint,
// fixed, length header and payload byte results.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock unless the output stalls, and gives at
// most one result per byte. Each accepted byte is held in an input register,
// decoded in one pass of logic against the parser state, and the result is
// placed in an output register, from which it is offered. A waiting result
// does not stop the next byte from being taken into the input register; the
// input side stalls only while both registers are full. The throughput is
// one byte per clock while results are taken.
// Keys with unknown wire types produce no result, and a field cut off by
// message_start produces no further result.
module protobuf_wire_field_parser_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pwfp_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                              s_message_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pwfp_pkg::KIND_W-1:0]       m_result_kind,
    output logic [pwfp_pkg::ID_W-1:0]         m_field_id,
    output logic [pwfp_pkg::VALUE_W-1:0]      m_field_value,
    output logic                              m_last_payload
);
    import pwfp_pkg::*;

    // input register
    logic                  in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_start_reg;

    // parser state
    phase_t                phase_reg, phase_next;
    logic [VALUE_W-1:0]    acc_reg, acc_next;
    logic [INDEX_W-1:0]    idx_reg, idx_next;
    logic [ID_W-1:0]       field_reg, field_next;
    logic [TYPE_W-1:0]     type_reg, type_next;
    logic [VALUE_W-1:0]    rem_reg, rem_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  step;
    logic                  emit;

    phase_t                eff_phase;
    logic [VALUE_W-1:0]    eff_acc;
    logic [INDEX_W-1:0]    eff_idx;
    logic [VALUE_W-1:0]    eff_rem;

    logic [5:0]            v_shamt;
    logic [VALUE_W-1:0]    v_acc;
    logic [INDEX_W-1:0]    v_idx;
    logic                  v_end;
    logic [VALUE_W-1:0]    f_acc;
    logic [INDEX_W-1:0]    f_idx;
    logic [INDEX_W-1:0]    f_need;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = out_kind_reg;
    assign m_field_id     = out_id_reg;
    assign m_field_value  = out_value_reg;
    assign m_last_payload = out_last_reg;

    // message start clears the partial item before the byte is used
    always_comb begin
        if (in_start_reg) begin
            eff_phase = PH_KEY;
            eff_acc   = '0;
            eff_idx   = '0;
            eff_rem   = '0;
        end else begin
            eff_phase = phase_reg;
            eff_acc   = acc_reg;
            eff_idx   = idx_reg;
            eff_rem   = rem_reg;
        end
    end

    // varint group and fixed byte accumulation
    always_comb begin
        v_shamt = {2'b00, eff_idx} * 6'd7;
        v_end   = !in_byte_reg[7];
        if (eff_idx < VARINT_MAX_GROUPS) begin
            v_acc = eff_acc | ({57'd0, in_byte_reg[6:0]} << v_shamt);
            v_idx = eff_idx + 4'd1;
        end else begin
            v_acc = eff_acc;
            v_idx = eff_idx;
        end
        f_acc  = eff_acc | ({56'd0, in_byte_reg} << {eff_idx[2:0], 3'b000});
        f_idx  = eff_idx + 4'd1;
        f_need = (type_reg == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
    end

    // next parser state
    always_comb begin
        phase_next     = eff_phase;
        acc_next       = eff_acc;
        idx_next       = eff_idx;
        field_next     = field_reg;
        type_next      = type_reg;
        rem_next       = eff_rem;
        emit           = 1'b0;
        out_kind_next  = KIND_VARINT;
        out_value_next = '0;
        out_last_next  = 1'b0;
        case (eff_phase)
            PH_VARINT: begin
                acc_next = v_acc;
                idx_next = v_idx;
                if (v_end) begin
                    emit           = 1'b1;
                    out_kind_next  = KIND_VARINT;
                    out_value_next = v_acc;
                    acc_next       = '0;
                    idx_next       = '0;
                    phase_next     = PH_KEY;
                end
            end
            PH_FIXED: begin
                acc_next = f_acc;
                idx_next = f_idx;
                if (f_idx >= f_need) begin
                    emit           = 1'b1;
                    out_kind_next  = (f_need == FIXED64_BYTES) ? KIND_FIXED64 : KIND_FIXED32;
                    out_value_next = f_acc;
                    acc_next       = '0;
                    idx_next       = '0;
                    phase_next     = PH_KEY;
                end
            end
            PH_LENGTH: begin
                acc_next = v_acc;
                idx_next = v_idx;
                if (v_end) begin
                    emit           = 1'b1;
                    out_kind_next  = KIND_LENGTH;
                    out_value_next = v_acc;
                    acc_next       = '0;
                    idx_next       = '0;
                    rem_next       = v_acc;
                    phase_next     = (v_acc == '0) ? PH_KEY : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                emit           = 1'b1;
                out_kind_next  = KIND_PAYLOAD;
                out_value_next = {56'd0, in_byte_reg};
                out_last_next  = (eff_rem <= 64'd1);
                if (eff_rem != '0) begin
                    rem_next = eff_rem - 64'd1;
                end
                if (eff_rem <= 64'd1) begin
                    phase_next = PH_KEY;
                end
            end
            default: begin
                phase_next = PH_KEY;
                acc_next   = v_acc;
                idx_next   = v_idx;
                if (v_end) begin
                    acc_next   = '0;
                    idx_next   = '0;
                    field_next = v_acc[ID_W+2:3];
                    type_next  = v_acc[TYPE_W-1:0];
                    case (v_acc[TYPE_W-1:0])
                        WT_VARINT:  phase_next = PH_VARINT;
                        WT_FIXED64: phase_next = PH_FIXED;
                        WT_FIXED32: phase_next = PH_FIXED;
                        WT_LENGTH:  phase_next = PH_LENGTH;
                        default:    phase_next = PH_KEY;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (step && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
        out_id_next = field_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_KEY;
            acc_reg       <= '0;
            idx_reg       <= '0;
            field_reg     <= '0;
            type_reg      <= '0;
            rem_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                idx_reg   <= idx_next;
                field_reg <= field_next;
                type_reg  <= type_next;
                rem_reg   <= rem_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_message_start;
        end
        if (step && emit) begin
            out_kind_reg  <= out_kind_next;
            out_id_reg    <= out_id_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule
